// ===== src/level_sensor_frame_average_unit_assert.svh =====
// Assertion macros for the level sensor frame average unit checkers.
`ifndef LEVEL_SENSOR_FRAME_AVERAGE_UNIT_ASSERT_SVH
`define LEVEL_SENSOR_FRAME_AVERAGE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define LSFA_CHECK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("level sensor frame average check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define LSFA_CHECK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("level sensor frame average check failed");

`endif

// ===== src/lsfa_pkg.sv =====
// Shared types and constants of the level sensor frame average unit.
package lsfa_pkg;

  // Field widths
  localparam int REQ_W       = 2;
  localparam int BYTE_W      = 8;
  localparam int DIST_W      = 16;
  localparam int AVG_W       = 20;
  localparam int FILL_W      = 14;
  localparam int COUNT_OUT_W = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - AVG_W - FILL_W - COUNT_OUT_W;

  // Defaults and fixed values
  localparam int MAX_READINGS_DEF = 16;
  localparam logic [DIST_W-1:0] MIN_DIST_RST = 16'd0;
  localparam logic [DIST_W-1:0] MAX_DIST_RST = 16'd4500;
  localparam logic [BYTE_W-1:0] HDR_BYTE     = 8'hFF;
  localparam int FILL_SCALE = 10000;
  // quotient at or above this on the negative side saturates the fill to zero
  localparam int FILL_SAT   = 99990000;
  localparam int AVG_SHIFT  = 4;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_START  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BYTE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_MUL_MIN,
    ST_MUL_RNG,
    ST_DIFF,
    ST_SIGN,
    ST_MUL_D,
    ST_FILL_GO,
    ST_FILL_WAIT,
    ST_DONE
  } lsfa_state_t;

endpackage

// ===== src/level_sensor_frame_average_unit.sv =====
// Level sensor frame average unit: top level with frame check and report sequencer.
//
// Input channel (in_*): one item per received sensor byte (tuser = request kind,
// tdata = byte), plus start and finish requests. Bytes form groups of four:
// header 0xFF, distance high, distance low, checksum. A checked group adds its
// clamped distance to the running sum, up to MAX_READINGS groups.
// Start and byte items do not leave the idle state; in_tready stays high for them.
// A finish item starts the report sequence and drops in_tready: with no valid
// reading it goes straight to the result; otherwise one pass of the shared
// bit-serial divider gives the average; unless max <= min, multiplier steps and,
// unless the average is at or below min, a second pass give the fill level.
// The result sits in an output register (out_*): tuser = readings_valid,
// tdata = avg_distance_q4 | fill_hundredths | reading_count from bit 0 up.
// While out_tready is low the result holds, start and byte items still flow,
// and a following finish waits in its last step until the register frees.
// Configuration (cfg_*) is always ready; write it only while the unit is idle.
// Reset (rst_n low, synchronous) clears the run, the registers to their
// defaults and drops out_tvalid.
module level_sensor_frame_average_unit
  import lsfa_pkg::*;
#(
  parameter int MAX_READINGS = MAX_READINGS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  input  logic [REQ_W-1:0]       in_tuser,   // [1:0] req_type
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [19:0] avg_distance_q4,
                                             // [33:20] fill_hundredths,
                                             // [38:34] reading_count, [39] zero
  output logic                   out_tuser,  // [0] readings_valid
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W  = $clog2(MAX_READINGS + 1);
  localparam int SUM_W  = DIST_W + CNT_W;
  localparam int MA_W   = (CNT_W > FILL_W) ? CNT_W : FILL_W;
  localparam int PROD_W = MA_W + SUM_W;

  lsfa_state_t state_r, state_nxt;

  logic [1:0]        pos_r, pos_nxt;
  logic [BYTE_W-1:0] hdr_r, hdr_nxt;
  logic [BYTE_W-1:0] hi_r, hi_nxt;
  logic [BYTE_W-1:0] lo_r, lo_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIST_W-1:0] min_r, max_r;

  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [SUM_W-1:0]  nmin_r, nmin_nxt;
  logic [SUM_W-1:0]  den_r, den_nxt;
  logic [SUM_W:0]    num_r, num_nxt;
  logic [SUM_W-1:0]  dmag_r, dmag_nxt;
  logic              neg_r, neg_nxt;
  logic [AVG_W-1:0]  avg_r, avg_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_user_r, out_user_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic              in_acc;
  logic [BYTE_W-1:0] chk_sum;
  logic [DIST_W-1:0] dist_raw;
  logic [DIST_W-1:0] dist_clamp;
  logic              frame_ok;
  logic [DIST_W-1:0] rng;

  // shared multiplier
  logic [MA_W-1:0]   mul_a;
  logic [SUM_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;

  // shared divider
  logic              div_start;
  logic [PROD_W-1:0] div_num;
  logic [SUM_W-1:0]  div_den;
  logic              div_done;
  logic [PROD_W-1:0] div_q;
  logic [PROD_W-1:0] div_q_neg;
  logic [SUM_W-1:0]  num_pos;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Frame check on the checksum byte
  assign chk_sum  = hdr_r + hi_r + lo_r;
  assign dist_raw = {hi_r, lo_r};
  assign frame_ok = (hdr_r == HDR_BYTE) && (chk_sum == in_tdata);

  // Upper clamp wins over lower clamp
  always_comb begin
    if (dist_raw > max_r) begin
      dist_clamp = max_r;
    end else if (dist_raw < min_r) begin
      dist_clamp = min_r;
    end else begin
      dist_clamp = dist_raw;
    end
  end

  assign rng       = max_r - min_r;
  assign mul_p     = mul_a * mul_b;
  assign div_q_neg = '0 - div_q;
  assign num_pos   = num_r[SUM_W-1:0];

  lsfa_div #(
    .NUM_W (PROD_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer: byte intake, report steps, result hand-off
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    hdr_nxt       = hdr_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    nmin_nxt      = nmin_r;
    den_nxt       = den_r;
    num_nxt       = num_r;
    dmag_nxt      = dmag_r;
    neg_nxt       = neg_r;
    avg_nxt       = avg_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_user_nxt  = out_user_r;
    out_data_nxt  = out_data_r;
    mul_a         = MA_W'(cnt_r);
    mul_b         = SUM_W'(min_r);
    div_start     = 1'b0;
    div_num       = PROD_W'({sum_r, {AVG_SHIFT{1'b0}}});
    div_den       = SUM_W'(cnt_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            REQ_START: begin
              pos_nxt = '0;
              sum_nxt = '0;
              cnt_nxt = '0;
            end
            REQ_BYTE: begin
              unique case (pos_r)
                2'd0: hdr_nxt = in_tdata;
                2'd1: hi_nxt  = in_tdata;
                2'd2: lo_nxt  = in_tdata;
                default: begin
                  if (frame_ok && (cnt_r < CNT_W'(MAX_READINGS))) begin
                    sum_nxt = sum_r + SUM_W'(dist_clamp);
                    cnt_nxt = cnt_r + 1'b1;
                  end
                end
              endcase
              pos_nxt = pos_r + 1'b1;
            end
            REQ_FINISH: begin
              if (cnt_r == '0) begin
                avg_nxt   = '0;
                fill_nxt  = '0;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_AVG_GO;
              end
            end
            // unused request code: ignored
            default: ;
          endcase
        end
      end
      ST_AVG_GO: begin
        div_start = 1'b1;
        state_nxt = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (div_done) begin
          avg_nxt = div_q[AVG_W-1:0];
          if (max_r <= min_r) begin
            fill_nxt  = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MUL_MIN;
          end
        end
      end
      ST_MUL_MIN: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_RNG;
      end
      ST_MUL_RNG: begin
        mul_b     = SUM_W'(rng);
        nmin_nxt  = prod_r[SUM_W-1:0];
        prod_nxt  = mul_p;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        den_nxt   = prod_r[SUM_W-1:0];
        num_nxt   = {1'b0, sum_r} - {1'b0, nmin_r};
        state_nxt = ST_SIGN;
      end
      ST_SIGN: begin
        // average at or below min reads as full
        if (num_r[SUM_W] || (num_r == '0)) begin
          fill_nxt  = FILL_W'(FILL_SCALE);
          state_nxt = ST_DONE;
        end else if (num_pos > den_r) begin
          dmag_nxt  = num_pos - den_r;
          neg_nxt   = 1'b1;
          state_nxt = ST_MUL_D;
        end else begin
          dmag_nxt  = den_r - num_pos;
          neg_nxt   = 1'b0;
          state_nxt = ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        mul_a     = MA_W'(FILL_SCALE);
        mul_b     = dmag_r;
        prod_nxt  = mul_p;
        state_nxt = ST_FILL_GO;
      end
      ST_FILL_GO: begin
        div_start = 1'b1;
        div_num   = prod_r;
        div_den   = den_r;
        state_nxt = ST_FILL_WAIT;
      end
      ST_FILL_WAIT: begin
        if (div_done) begin
          // negative side truncates toward zero; far below zero saturates
          if (!neg_r) begin
            fill_nxt = div_q[FILL_W-1:0];
          end else if (div_q >= PROD_W'(FILL_SAT)) begin
            fill_nxt = '0;
          end else begin
            fill_nxt = div_q_neg[FILL_W-1:0];
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = (cnt_r != '0);
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, COUNT_OUT_W'(cnt_r), fill_r, avg_r};
          pos_nxt       = '0;
          sum_nxt       = '0;
          cnt_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and run registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_DIST_RST;
      max_r <= MAX_DIST_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MIN_DIST) begin
        min_r <= cfg_data;
      end else if (cfg_index == CFG_MAX_DIST) begin
        max_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hdr_r      <= hdr_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    prod_r     <= prod_nxt;
    nmin_r     <= nmin_nxt;
    den_r      <= den_nxt;
    num_r      <= num_nxt;
    dmag_r     <= dmag_nxt;
    neg_r      <= neg_nxt;
    avg_r      <= avg_nxt;
    fill_r     <= fill_nxt;
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/lsfa_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module lsfa_div
  import lsfa_pkg::*;
#(
  parameter int NUM_W = 35,
  parameter int DEN_W = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] dvs_r, dvs_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;

  // One shift-and-subtract step
  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sub[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/lsfa_checker.sv =====
// Port-level checks for the level sensor frame average unit, bound to the top level.
`include "level_sensor_frame_average_unit_assert.svh"

module lsfa_checker
  import lsfa_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  // a stalled result holds
  `LSFA_CHECK_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // a report without readings is all zero
  `LSFA_CHECK_IMP(a_empty_zero, out_tvalid && !out_tuser, out_tdata == '0)

  // average never exceeds the largest distance in sixteenths
  `LSFA_CHECK_IMP(a_avg_range, out_tvalid, out_tdata[AVG_W-1:0] <= 20'd1048560)

  // configuration writes are never held off
  `LSFA_CHECK_IMP(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind level_sensor_frame_average_unit lsfa_checker u_lsfa_checker (.*);

// ===== sim/level_sensor_frame_average_unit_test.sv =====
// Testbench for the level sensor frame average unit: stream stimulus, report prediction, checks.
`timescale 1ns / 100ps

module level_sensor_frame_average_unit_test;
  import lsfa_pkg::*;

  localparam int READING_LIMIT = MAX_READINGS_DEF;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 120;    // extra wait once the queues are empty
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 170;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [BYTE_W-1:0] data;
  } sensor_item_t;

  typedef struct packed {
    logic                   valid;
    logic [AVG_W-1:0]       avg_q4;
    logic [FILL_W-1:0]      fill;
    logic [COUNT_OUT_W-1:0] count;
  } level_report_t;

  typedef enum int {FRAME_GOOD, FRAME_BAD_HEADER, FRAME_BAD_SUM, FRAME_SHORT} frame_flaw_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [REQ_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  level_sensor_frame_average_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // stimulus and expectations
  sensor_item_t  sensor_items_q[$];
  level_report_t expected_reports[$];

  // predictor copy of the unit
  logic [DIST_W-1:0]      range_min_mm = MIN_DIST_RST;
  logic [DIST_W-1:0]      range_max_mm = MAX_DIST_RST;
  logic [1:0]             byte_pos = '0;
  logic [BYTE_W-1:0]      hdr_byte, dist_hi, dist_lo;
  logic [AVG_W-1:0]       dist_sum = '0;
  logic [COUNT_OUT_W-1:0] frame_count = '0;

  // run bookkeeping
  logic calm = 1'b0;
  logic in_fire = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   mismatches = 0;
  int   items_sent = 0;
  int   reports_seen = 0;
  int   reports_with_readings = 0;
  int   settings_used = 0;

  // fill level in hundredths of a percent, exact from sum and count
  function automatic int fill_from_sum(logic [AVG_W-1:0] sum, int n,
                                       logic [DIST_W-1:0] lo_mm, logic [DIST_W-1:0] hi_mm);
    longint num;
    longint den;
    if (hi_mm <= lo_mm) return 0;
    num = longint'(sum) - longint'(n) * longint'(lo_mm);
    den = longint'(n) * longint'(hi_mm - lo_mm);
    if (num <= 0) return FILL_SCALE;
    if (num >= longint'(FILL_SCALE) * den) return 0;
    return int'((longint'(FILL_SCALE) * den - num * longint'(FILL_SCALE)) / den);
  endfunction

  task automatic clear_accumulation();
    byte_pos = '0;
    dist_sum = '0;
    frame_count = '0;
  endtask

  // advance the predictor by one accepted item
  task automatic track_sensor_item(logic [REQ_W-1:0] kind, logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] sum8;
    logic [DIST_W-1:0] d;
    level_report_t rep;
    case (kind)
      REQ_START: clear_accumulation();
      REQ_BYTE: begin
        case (byte_pos)
          2'd0: hdr_byte = b;
          2'd1: dist_hi = b;
          2'd2: dist_lo = b;
          default: begin
            sum8 = hdr_byte + dist_hi + dist_lo;
            if (hdr_byte == HDR_BYTE && sum8 == b) begin
              d = {dist_hi, dist_lo};
              if (d > range_max_mm) d = range_max_mm;
              else if (d < range_min_mm) d = range_min_mm;
              if (frame_count < READING_LIMIT) begin
                dist_sum = dist_sum + d;
                frame_count = frame_count + 1'b1;
              end
            end
          end
        endcase
        byte_pos = byte_pos + 1'b1;
      end
      REQ_FINISH: begin
        rep = '0;
        if (frame_count != 0) begin
          rep.valid  = 1'b1;
          rep.avg_q4 = AVG_W'((longint'(dist_sum) * 16) / frame_count);
          rep.fill   = FILL_W'(fill_from_sum(dist_sum, int'(frame_count),
                                             range_min_mm, range_max_mm));
          rep.count  = frame_count;
        end
        expected_reports.push_back(rep);
        clear_accumulation();
      end
      default: ;  // unused code: ignored
    endcase
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // monitor: input handshakes feed the predictor, results are checked in order
  always @(posedge clk) begin
    level_report_t exp_rep;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) track_sensor_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report: expected none, actual tuser %0b tdata %h",
                   $time, out_tuser, out_tdata);
          mismatches++;
        end else begin
          exp_rep = expected_reports.pop_front();
          if (exp_rep.valid) reports_with_readings++;
          check_field("readings_valid", exp_rep.valid, out_tuser);
          check_field("avg_distance_q4", exp_rep.avg_q4, out_tdata[AVG_W-1:0]);
          check_field("fill_hundredths", exp_rep.fill,
                      out_tdata[AVG_W+FILL_W-1:AVG_W]);
          check_field("reading_count", exp_rep.count,
                      out_tdata[AVG_W+FILL_W+COUNT_OUT_W-1:AVG_W+FILL_W]);
        end
      end
    end
  end

  // driver: one item per handshake, random gaps between items
  always @(negedge clk) begin
    sensor_item_t next_item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // hold until taken
    end else if (in_gap > 0) begin
      in_tvalid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (sensor_items_q.size() != 0) begin
      next_item = sensor_items_q.pop_front();
      in_tvalid <= 1'b1;
      in_tuser <= next_item.kind;
      in_tdata <= next_item.data;
      if (!calm && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 12);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap <= out_gap - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      out_gap <= $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic add_item(logic [REQ_W-1:0] kind, logic [BYTE_W-1:0] data);
    sensor_items_q.push_back('{kind: kind, data: data});
    if (kind != REQ_UNUSED) items_sent++;
  endtask

  // four-byte sensor frame, optionally broken
  task automatic add_frame(logic [DIST_W-1:0] d, frame_flaw_t flaw);
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] sum8;
    int n;
    hdr = (flaw == FRAME_BAD_HEADER) ? BYTE_W'($urandom_range(0, 254)) : HDR_BYTE;
    sum8 = hdr + d[15:8] + d[7:0];
    if (flaw == FRAME_BAD_SUM) sum8 = sum8 + BYTE_W'($urandom_range(1, 255));
    n = (flaw == FRAME_SHORT) ? $urandom_range(1, 3) : 4;
    add_item(REQ_BYTE, hdr);
    if (n > 1) add_item(REQ_BYTE, d[15:8]);
    if (n > 2) add_item(REQ_BYTE, d[7:0]);
    if (n > 3) add_item(REQ_BYTE, sum8);
  endtask

  // distances that land on, near and beyond the clamp limits
  function automatic logic [DIST_W-1:0] pick_distance();
    logic [DIST_W-1:0] d;
    case ($urandom_range(0, 5))
      0: d = DIST_W'($urandom_range(0, 65535));
      1: d = range_min_mm + DIST_W'($urandom_range(0, 6)) - 16'd3;
      2: d = range_max_mm + DIST_W'($urandom_range(0, 6)) - 16'd3;
      3: d = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      default:
        if (range_min_mm <= range_max_mm)
          d = DIST_W'($urandom_range(int'(range_min_mm), int'(range_max_mm)));
        else
          d = DIST_W'($urandom_range(0, 65535));
    endcase
    return d;
  endfunction

  // one measurement run: usually a start, frames with some damage and noise, usually a finish
  task automatic queue_level_run(int frames);
    int r;
    frame_flaw_t flaw;
    if ($urandom_range(0, 3) != 0) add_item(REQ_START, BYTE_W'($urandom));
    for (int i = 0; i < frames; i++) begin
      r = $urandom_range(0, 99);
      flaw = (r < 80) ? FRAME_GOOD : (r < 87) ? FRAME_BAD_HEADER :
             (r < 94) ? FRAME_BAD_SUM : FRAME_SHORT;
      add_frame(pick_distance(), flaw);
      if ($urandom_range(0, 19) == 0) add_item(REQ_UNUSED, BYTE_W'($urandom));
      if ($urandom_range(0, 39) == 0) add_item(REQ_START, BYTE_W'($urandom));
    end
    if ($urandom_range(0, 19) != 0) add_item(REQ_FINISH, BYTE_W'($urandom));
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (sensor_items_q.size() != 0 || in_tvalid || expected_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_MIN_DIST) range_min_mm = value;
    else range_max_mm = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // main sequence
  initial begin
    int phase_min [PHASES];
    int phase_max [PHASES];
    int lo_mm;
    int hi_mm;
    int start_items;
    phase_min = '{0, 0, 65535, 1200, 65535, 0, 100};
    phase_max = '{4500, 65535, 0, 1200, 65535, 0, 400};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extreme frames, broken frames, unused code, empty and partial runs
    add_item(REQ_START, 8'hFF);
    add_frame(16'h0000, FRAME_GOOD);
    add_frame(16'hFFFF, FRAME_GOOD);
    add_frame(16'd1000, FRAME_BAD_SUM);
    add_item(REQ_BYTE, 8'h00);
    add_item(REQ_BYTE, 8'h01);
    add_item(REQ_BYTE, 8'h02);
    add_item(REQ_BYTE, 8'h03);
    add_item(REQ_UNUSED, 8'hFF);
    add_item(REQ_FINISH, 8'h00);
    add_item(REQ_FINISH, 8'hAA);
    add_item(REQ_BYTE, 8'hFF);
    add_item(REQ_BYTE, 8'h10);
    add_item(REQ_START, 8'h55);
    add_item(REQ_FINISH, 8'h00);
    wait_until_drained();

    // random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      lo_mm = phase_min[p];
      hi_mm = phase_max[p];
      if (p == 5) begin
        lo_mm = $urandom_range(0, 30000);
        hi_mm = lo_mm + $urandom_range(1, 35535);
      end
      write_register(CFG_MIN_DIST, DIST_W'(lo_mm));
      write_register(CFG_MAX_DIST, DIST_W'(hi_mm));
      settings_used++;
      calm = (p == PHASES - 1);
      start_items = items_sent;
      while (items_sent - start_items < PHASE_ITEMS)
        queue_level_run(($urandom_range(0, 3) == 0) ? $urandom_range(9, 20)
                                                    : $urandom_range(0, 8));
      wait_until_drained();
    end

    $display("Sent %0d sensor items under %0d register settings plus reset values.",
             items_sent, settings_used);
    $display("Checked %0d reports, %0d of them with valid readings.",
             reports_seen, reports_with_readings);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
